// ----- src/tcet_pkg.sv -----
// ----------------------------------------------------------------------------
// Touch contact event tracker package
// Sizes, command and event codes, channel payloads and the controller
// interface shared by the tracker modules.
// ----------------------------------------------------------------------------
package tcet_pkg;

   // Number of contact ids held in the position table (1 to 16).
   localparam int MAX_TOUCH_IDS       = 16;
   // Largest contact count of a report that is not dropped (1 to 15).
   localparam int MAX_REPORT_CONTACTS = 5;

   localparam int ID_W         = (MAX_TOUCH_IDS > 1) ? $clog2(MAX_TOUCH_IDS) : 1;
   localparam int COORD_W      = 12;
   localparam int RESULT_LIMIT = 16;
   localparam int UP_CNT_W     = $clog2(RESULT_LIMIT);

   localparam logic [7:0] PEN_MASK = 8'h80;

   localparam logic [1:0] CMD_BEGIN   = 2'd0;
   localparam logic [1:0] CMD_CONTACT = 2'd1;
   localparam logic [1:0] CMD_END     = 2'd2;

   localparam logic [1:0] EV_DOWN = 2'd0;
   localparam logic [1:0] EV_MOVE = 2'd1;
   localparam logic [1:0] EV_UP   = 2'd2;

   typedef struct packed {
      logic [1:0]  command;
      logic [3:0]  contact_count;
      logic [7:0]  contact_id;
      logic [15:0] raw_x;
      logic [15:0] raw_y;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]         event_kind;
      logic [3:0]         touch_id;
      logic [COORD_W-1:0] pos_x;
      logic [COORD_W-1:0] pos_y;
      logic               last_of_run;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_item;
      logic exec_begin;
      logic exec_contact;
      logic exec_end;
      logic emit_up;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [1:0] item_cmd;
      logic       contact_result;
      logic       end_has_release;
      logic       scan_last;
      logic       out_free;
   } dp_status_type;

endpackage

// ----- src/tcet_req_if.sv -----
// ----------------------------------------------------------------------------
// Touch report channel
// Valid/ready channel that carries one report item per transfer.
// ----------------------------------------------------------------------------
interface tcet_req_if;
   import tcet_pkg::*;

   logic            valid;
   logic            ready;
   req_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ----- src/tcet_rsp_if.sv -----
// ----------------------------------------------------------------------------
// Touch event channel
// Valid/ready channel that carries one touch event per transfer.
// ----------------------------------------------------------------------------
interface tcet_rsp_if;
   import tcet_pkg::*;

   logic            valid;
   logic            ready;
   rsp_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ----- src/touch_contact_event_tracker.sv -----
// ----------------------------------------------------------------------------
// Touch contact event tracker
// Turns touch-controller reports into finger down, move and up events.
// ----------------------------------------------------------------------------
// Each report item is registered when taken and then executed; a contact
// that raises an event waits until the event output register is free. An
// end of report that releases N tracked ids (N up to 16) then scans them,
// one finger-up event per cycle while the event channel takes them, through
// the single output register.
// A contact whose id is not tracked yet gives finger down, a tracked id
// whose 12-bit position changed gives finger move, and the end of a report
// gives finger up for every tracked id missing from it, lowest id first,
// with last_of_run set on the final one. Reports with too many contacts,
// and single-contact pen reports, are dropped without touching the set of
// tracked ids. Contact ids at or above the table size are ignored. Events
// wait in an output register, so a new item is taken while an earlier
// event has not yet been transferred.
// ----------------------------------------------------------------------------
module touch_contact_event_tracker (
   input  logic        clock,
   input  logic        reset,
   tcet_req_if.sink    req_chan,
   tcet_rsp_if.source  rsp_chan
);
   import tcet_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // The controller owns the input handshake and steps the datapath.
   tcet_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds all tracking state and the event output register.
   tcet_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_chan.data),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_data  (rsp_chan.data)
   );

endmodule

// ----- src/tcet_datapath.sv -----
// ----------------------------------------------------------------------------
// Touch tracker datapath
// Item register, id masks, position table, release scan and event output
// register.
// ----------------------------------------------------------------------------
module tcet_datapath (
   input  logic                      clock,
   input  logic                      reset,
   input  tcet_pkg::dp_cmd_type      cmd,
   output tcet_pkg::dp_status_type   status,
   input  tcet_pkg::req_payload_type req_data,
   input  logic                      rsp_ready,
   output logic                      rsp_valid,
   output tcet_pkg::rsp_payload_type rsp_data
);
   import tcet_pkg::*;

   req_payload_type item_ff;

   logic [MAX_TOUCH_IDS-1:0] known_ff, known_in;
   logic [MAX_TOUCH_IDS-1:0] active_ff, active_in;
   logic [MAX_TOUCH_IDS-1:0] rel_ff, rel_in;
   logic [3:0]               size_ff, size_in;
   logic                     dropped_ff, dropped_in;
   logic [UP_CNT_W-1:0]      up_cnt_ff, up_cnt_in;

   logic [COORD_W-1:0] pos_x_ff [MAX_TOUCH_IDS];
   logic [COORD_W-1:0] pos_y_ff [MAX_TOUCH_IDS];

   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   logic [ID_W-1:0]          idx;
   logic [MAX_TOUCH_IDS-1:0] id_bit;
   logic [COORD_W-1:0]       x_new, y_new;
   logic                     in_range, is_pen, is_known, pos_changed, pos_write;

   logic [ID_W-1:0]          up_idx;
   logic [MAX_TOUCH_IDS-1:0] up_bit;
   logic [MAX_TOUCH_IDS-1:0] rel_next;
   logic                     out_free;

   assign idx         = item_ff.contact_id[ID_W-1:0];
   assign id_bit      = MAX_TOUCH_IDS'(1) << idx;
   assign x_new       = item_ff.raw_x[COORD_W-1:0];
   assign y_new       = item_ff.raw_y[COORD_W-1:0];
   assign in_range    = item_ff.contact_id < 8'(MAX_TOUCH_IDS);
   assign is_pen      = (size_ff == 4'd1) && ((item_ff.contact_id & PEN_MASK) != 8'd0);
   assign is_known    = (known_ff & id_bit) != '0;
   assign pos_changed = (x_new != pos_x_ff[idx]) || (y_new != pos_y_ff[idx]);
   assign out_free    = !rsp_valid_ff || rsp_ready;

   // Lowest pending release.
   always_comb begin
      up_idx = '0;
      for (int i = MAX_TOUCH_IDS - 1; i >= 0; i--) begin
         if (rel_ff[i]) begin
            up_idx = ID_W'(i);
         end
      end
   end

   assign up_bit   = MAX_TOUCH_IDS'(1) << up_idx;
   assign rel_next = rel_ff & ~up_bit;

   always_comb begin
      status.item_cmd        = item_ff.command;
      status.contact_result  = !dropped_ff && !is_pen && in_range && (!is_known || pos_changed);
      status.end_has_release = !dropped_ff && ((known_ff & ~active_ff) != '0);
      status.scan_last       = (rel_next == '0) || (up_cnt_ff == UP_CNT_W'(RESULT_LIMIT - 1));
      status.out_free        = out_free;
   end

   always_comb begin
      known_in     = known_ff;
      active_in    = active_ff;
      rel_in       = rel_ff;
      size_in      = size_ff;
      dropped_in   = dropped_ff;
      up_cnt_in    = up_cnt_ff;
      pos_write    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      if (cmd.exec_begin) begin
         size_in    = item_ff.contact_count;
         dropped_in = item_ff.contact_count > 4'(MAX_REPORT_CONTACTS);
         active_in  = '0;
      end

      if (cmd.exec_contact && !dropped_ff) begin
         if (is_pen) begin
            dropped_in = 1'b1;
         end else if (in_range) begin
            active_in = active_ff | id_bit;
            if (!is_known || pos_changed) begin
               pos_write                = 1'b1;
               rsp_valid_in             = 1'b1;
               rsp_data_in.event_kind   = is_known ? EV_MOVE : EV_DOWN;
               rsp_data_in.touch_id     = 4'(idx);
               rsp_data_in.pos_x        = x_new;
               rsp_data_in.pos_y        = y_new;
               rsp_data_in.last_of_run  = 1'b1;
            end
         end
      end

      if (cmd.exec_end) begin
         dropped_in = 1'b0;
         active_in  = '0;
         if (!dropped_ff) begin
            rel_in    = known_ff & ~active_ff;
            known_in  = active_ff;
            up_cnt_in = '0;
         end
      end

      if (cmd.emit_up) begin
         rel_in                  = rel_next;
         up_cnt_in               = up_cnt_ff + UP_CNT_W'(1);
         rsp_valid_in            = 1'b1;
         rsp_data_in.event_kind  = EV_UP;
         rsp_data_in.touch_id    = 4'(up_idx);
         rsp_data_in.pos_x       = '0;
         rsp_data_in.pos_y       = '0;
         rsp_data_in.last_of_run = status.scan_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         known_ff     <= '0;
         active_ff    <= '0;
         size_ff      <= '0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         known_ff     <= known_in;
         active_ff    <= active_in;
         size_ff      <= size_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rel_ff      <= rel_in;
      up_cnt_ff   <= up_cnt_in;
      rsp_data_ff <= rsp_data_in;
      if (cmd.load_item) begin
         item_ff <= req_data;
      end
      if (pos_write) begin
         pos_x_ff[idx] <= x_new;
         pos_y_ff[idx] <= y_new;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- src/tcet_controller.sv -----
// ----------------------------------------------------------------------------
// Touch tracker controller
// Sequences item intake, execution and the finger-up scan.
// ----------------------------------------------------------------------------
module tcet_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  tcet_pkg::dp_status_type status,
   output tcet_pkg::dp_cmd_type    cmd
);
   import tcet_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_EXEC;
            end
         end
         ST_EXEC: begin
            unique case (status.item_cmd)
               CMD_BEGIN: begin
                  cmd.exec_begin = 1'b1;
                  state_in       = ST_IDLE;
               end
               CMD_CONTACT: begin
                  // A contact that raises an event waits for a free output register.
                  if (!status.contact_result || status.out_free) begin
                     cmd.exec_contact = 1'b1;
                     state_in         = ST_IDLE;
                  end
               end
               CMD_END: begin
                  cmd.exec_end = 1'b1;
                  state_in     = status.end_has_release ? ST_SCAN : ST_IDLE;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_SCAN: begin
            if (status.out_free) begin
               cmd.emit_up = 1'b1;
               if (status.scan_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
